FILE: rtl/uredg_pkg.sv
// Shared types and constants for the UART register datagram engine.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package uredg_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  // Reply counter width; covers reply lengths up to 16 bytes.
  localparam int CNT_W = 4;

  // First and last reply byte that carries the register value.
  localparam logic [CNT_W-1:0] VALUE_FIRST_IDX = 4'd7;
  localparam logic [CNT_W-1:0] VALUE_LAST_IDX  = 4'd10;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_RX     = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CMD_READ_REQ  = 2'd0,
    CMD_WRITE_REQ = 2'd1,
    CMD_READ_DONE = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    RES_TX_BYTE   = 1'b0,
    RES_READ_DONE = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic [31:0] read_value;
    logic        last;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  slave;
    logic [7:0]  addr_byte;
    logic [31:0] value;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/uredg_front.sv
// Front end: accepts input words, tracks the pending read reply and queues commands.
// Depends on uredg_pkg.
`default_nettype none

module uredg_front
  import uredg_pkg::*;
#(
  parameter int REPLY_BYTES = 12
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  localparam logic [CNT_W:0] REPLY_LIM = (CNT_W+1)'(REPLY_BYTES);

  logic [7:0]       slave_r;
  logic             pending_r, pending_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      accum_r, accum_nxt;
  logic             accept;
  logic [CNT_W:0]   cnt_inc;
  req_type_t        req;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign req      = req_type_t'(in_word.req_type);
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    pending_nxt     = pending_r;
    cnt_nxt         = cnt_r;
    accum_nxt       = accum_r;
    q_push          = 1'b0;
    q_cmd.kind      = CMD_READ_REQ;
    q_cmd.slave     = slave_r;
    q_cmd.addr_byte = {1'b0, in_word.reg_addr};
    q_cmd.value     = in_word.write_value;
    if (accept) begin
      case (req)
        REQ_READ: begin
          q_push      = 1'b1;
          pending_nxt = 1'b1;
          cnt_nxt     = '0;
          accum_nxt   = '0;
        end
        REQ_WRITE: begin
          q_push          = 1'b1;
          q_cmd.kind      = CMD_WRITE_REQ;
          q_cmd.addr_byte = {1'b1, in_word.reg_addr};
        end
        REQ_RX: begin
          if (pending_r) begin
            if (cnt_r >= VALUE_FIRST_IDX && cnt_r <= VALUE_LAST_IDX) begin
              accum_nxt = {accum_r[23:0], in_word.rx_byte};
            end
            cnt_nxt = cnt_inc[CNT_W-1:0];
            if (cnt_inc >= REPLY_LIM) begin
              pending_nxt = 1'b0;
              cnt_nxt     = '0;
              q_push      = 1'b1;
              q_cmd.kind  = CMD_READ_DONE;
              q_cmd.value = accum_nxt;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r   <= '0;
      pending_r <= 1'b0;
      cnt_r     <= '0;
      accum_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        slave_r <= cfg_wr_data;
      end
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
      accum_r   <= accum_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uredg_queue.sv
// Two-entry command queue between front and back.
// Depends on uredg_pkg.
`default_nettype none

module uredg_queue
  import uredg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uredg_back.sv
// Back end: serializes queued commands to words, one per cycle unless stalled; running CRC-8.
// Depends on uredg_pkg.
`default_nettype none

module uredg_back
  import uredg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire cmd_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  // CRC-8, data fed least significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  logic [2:0] idx_r, idx_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  logic [2:0] last_idx;
  logic [7:0] cur_byte;
  logic       out_free, fire, at_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = head_valid && out_free;
  assign last_idx  = (head.kind == CMD_WRITE_REQ) ? 3'd7 : 3'd3;
  assign at_last   = (idx_r == last_idx);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    if (at_last) begin
      cur_byte = crc_r;
    end else begin
      case (idx_r)
        3'd0:    cur_byte = SYNC_BYTE;
        3'd1:    cur_byte = head.slave;
        3'd2:    cur_byte = head.addr_byte;
        3'd3:    cur_byte = head.value[31:24];
        3'd4:    cur_byte = head.value[23:16];
        3'd5:    cur_byte = head.value[15:8];
        3'd6:    cur_byte = head.value[7:0];
        default: cur_byte = crc_r;
      endcase
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    pop           = 1'b0;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (head.kind == CMD_READ_DONE) begin
        pop                      = 1'b1;
        out_word_nxt.result_kind = RES_READ_DONE;
        out_word_nxt.tx_byte     = '0;
        out_word_nxt.read_value  = head.value;
        out_word_nxt.last        = 1'b1;
      end else begin
        out_word_nxt.result_kind = RES_TX_BYTE;
        out_word_nxt.tx_byte     = cur_byte;
        out_word_nxt.read_value  = '0;
        out_word_nxt.last        = at_last;
        if (at_last) begin
          pop     = 1'b1;
          idx_nxt = '0;
          crc_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          crc_nxt = crc8_byte(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/uart_register_datagram_engine.sv
// UART register datagram engine: master side of a single-wire register protocol.
// Each command yields registered result words: a write eight, a read request four and
// a completed reply one, as the back end emits one byte per cycle while not stalled;
// received bytes are absorbed at 1/cycle while the command queue is not full.
// Reset: synchronous active-low rst_n clears the slave address, read tracking,
// command queue, back-end byte index and CRC, and output valid flag.
`default_nettype none

module uart_register_datagram_engine
  import uredg_pkg::*;
#(
  parameter int REPLY_BYTES = 12
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word
);

  logic   q_push;
  logic   q_full;
  cmd_t   push_cmd;
  cmd_t   head_cmd;
  logic   q_empty;
  logic   q_pop;

  // Front: classify words, track the pending read, queue commands.
  uredg_front #(
    .REPLY_BYTES(REPLY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  // Decouple front and back so each can stall on its own.
  uredg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head_cmd)
  );

  // Back: expand each command into result words, computing the CRC on the fly.
  uredg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(!q_empty),
    .head      (head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
